/* rtl/pvc_pkg.sv */
// Shared constants, register codes, types and a helper function for the printable Vigenere cipher.
`timescale 1ns / 1ps

package pvc_pkg;

  localparam int KEY_CHARS  = 16;
  localparam int KEY_IDX_W  = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CHARS_PER_WORD = CFG_DATA_W / 8;

  localparam logic [7:0] ALPHABET      = 8'd95;
  localparam logic [7:0] FIRST_PRINT   = 8'd32;
  localparam logic [7:0] LAST_PRINT    = 8'd126;
  localparam logic [8:0] SHIFT_OFFSET  = 9'd63;   // -32 mod 95

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW  = 8'd0,
    REG_KEY_HIGH = 8'd1,
    REG_KEY_LEN  = 8'd2,
    REG_DECRYPT  = 8'd3
  } cfg_reg_t;

  typedef logic [7:0] key_char_t;
  typedef logic [6:0] shift_t;

  // (kb - 32) mod 95 for any key byte
  function automatic shift_t key_shift(input key_char_t kb);
    logic [8:0] v;
    logic [8:0] r;
    v = {1'b0, kb} + SHIFT_OFFSET;
    if (v >= 9'd285) begin
      r = v - 9'd285;
    end else if (v >= 9'd190) begin
      r = v - 9'd190;
    end else if (v >= 9'd95) begin
      r = v - 9'd95;
    end else begin
      r = v;
    end
    return r[6:0];
  endfunction

endpackage

/* rtl/pvc_ifs.sv */
// Stream and configuration channel interfaces for the printable Vigenere cipher.
`timescale 1ns / 1ps

interface pvc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_of_message;
  modport source (output valid, output text_byte, output last_of_message, input ready);
  modport sink   (input valid, input text_byte, input last_of_message, output ready);
endinterface

interface pvc_cipher_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       last_out;
  modport source (output valid, output cipher_byte, output last_out, input ready);
  modport sink   (input valid, input cipher_byte, input last_out, output ready);
endinterface

interface pvc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pvc_pkg::CFG_IDX_W-1:0]    index;
  logic [pvc_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/printable_vigenere_cipher_unit.sv */
// Top level of the printable Vigenere cipher: key registers, key position and two-stage pipe.
`timescale 1ns / 1ps

// Takes one text byte per cycle and returns one result byte per input, in order, through the
// input stage and then the result register. Throughput is one byte per cycle as long
// as the result side takes results; a stalled result lets one more byte in before text_in.ready
// drops. The key position advances on every accepted byte and returns to zero after a byte
// flagged last_of_message. Configuration writes are taken every cycle and should only be issued
// while no byte is in flight.
module printable_vigenere_cipher_unit (
  input  logic                clk,
  input  logic                rst,
  pvc_text_if.sink            text_in,
  pvc_cipher_if.source        cipher_out,
  pvc_cfg_if.sink             cfg
);

  localparam int IW = pvc_pkg::KEY_IDX_W;
  localparam int LW = pvc_pkg::LEN_W;

  pvc_pkg::key_char_t key_char [pvc_pkg::KEY_CHARS];
  logic [LW-1:0]      key_length;
  logic               decrypt_mode;
  logic [IW-1:0]      key_position;
  logic [IW-1:0]      key_position_next;

  logic               s1_valid;
  logic [7:0]         s1_text;
  logic               s1_last;
  pvc_pkg::shift_t    s1_shift;

  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_last;

  logic               advance;
  logic               in_xfer;
  logic [LW-1:0]      len_eff;
  logic [IW-1:0]      pos;
  logic [LW-1:0]      pos_inc;
  logic [7:0]         cipher_byte;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pvc_pkg::KEY_CHARS; i++) begin
        key_char[i] <= '0;
      end
      key_length   <= LW'(1);
      decrypt_mode <= 1'b0;
    end else if (cfg.valid) begin
      for (int i = 0; i < pvc_pkg::KEY_CHARS; i++) begin
        if ((i / pvc_pkg::CHARS_PER_WORD == 0 && cfg.index == pvc_pkg::REG_KEY_LOW) ||
            (i / pvc_pkg::CHARS_PER_WORD == 1 && cfg.index == pvc_pkg::REG_KEY_HIGH)) begin
          key_char[i] <= cfg.data[(i % pvc_pkg::CHARS_PER_WORD)*8 +: 8];
        end
      end
      if (cfg.index == pvc_pkg::REG_KEY_LEN) begin
        key_length <= cfg.data[LW-1:0];
      end
      if (cfg.index == pvc_pkg::REG_DECRYPT) begin
        decrypt_mode <= cfg.data[0];
      end
    end
  end

  // key position
  always_comb begin
    if (key_length == '0) begin
      len_eff = LW'(1);
    end else if (key_length > LW'(pvc_pkg::KEY_CHARS)) begin
      len_eff = LW'(pvc_pkg::KEY_CHARS);
    end else begin
      len_eff = key_length;
    end
    pos     = ({1'b0, key_position} >= (IW+1)'(len_eff)) ? '0 : key_position;
    pos_inc = LW'(pos) + LW'(1);
    if (text_in.last_of_message || pos_inc >= len_eff) begin
      key_position_next = '0;
    end else begin
      key_position_next = pos_inc[IW-1:0];
    end
  end

  // pipeline control
  assign advance       = !out_valid || cipher_out.ready;
  assign text_in.ready = !s1_valid || advance;
  assign in_xfer       = text_in.valid && text_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
      s1_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_xfer) begin
        key_position <= key_position_next;
      end
      if (text_in.ready) begin
        s1_valid <= text_in.valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_text  <= text_in.text_byte;
      s1_last  <= text_in.last_of_message;
      s1_shift <= pvc_pkg::key_shift(key_char[pos]);
    end
    if (advance && s1_valid) begin
      out_byte <= cipher_byte;
      out_last <= s1_last;
    end
  end

  pvc_shift u_shift (
    .text_byte   (s1_text),
    .shift       (s1_shift),
    .decrypt     (decrypt_mode),
    .cipher_byte (cipher_byte)
  );

  assign cipher_out.valid       = out_valid;
  assign cipher_out.cipher_byte = out_byte;
  assign cipher_out.last_out    = out_last;

  // checks
  a_last_clears_pos: assert property (@(posedge clk) disable iff (rst)
    in_xfer && text_in.last_of_message |=> key_position == '0)
    else $error("key position not cleared after last byte");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_text) && $stable(s1_shift))
    else $error("input stage lost data while stalled");

  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |-> !text_in.ready)
    else $error("byte accepted into a full pipe");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1_shift < 7'd95)
    else $error("key shift out of range");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !cipher_out.ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result register changed while stalled");

endmodule

/* rtl/pvc_shift.sv */
// Shifts one printable byte over the 95-character alphabet; other bytes pass unchanged.
`timescale 1ns / 1ps

module pvc_shift (
  input  logic [7:0]      text_byte,
  input  pvc_pkg::shift_t shift,
  input  logic            decrypt,
  output logic [7:0]      cipher_byte
);

  logic       printable;
  logic [6:0] sym;
  logic [7:0] sum;
  logic [7:0] wrapped;

  always_comb begin
    printable = (text_byte >= pvc_pkg::FIRST_PRINT) && (text_byte <= pvc_pkg::LAST_PRINT);
    sym       = 7'(text_byte - pvc_pkg::FIRST_PRINT);
    if (decrypt) begin
      sum = {1'b0, sym} + pvc_pkg::ALPHABET - {1'b0, shift};
    end else begin
      sum = {1'b0, sym} + {1'b0, shift};
    end
    wrapped = (sum >= pvc_pkg::ALPHABET) ? (sum - pvc_pkg::ALPHABET) : sum;
    cipher_byte = printable ? (wrapped + pvc_pkg::FIRST_PRINT) : text_byte;
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the printable Vigenere cipher unit: directed and random streams.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 40;
  localparam logic [pvc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd4;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_out;
  } cipher_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pvc_text_if   text_ch ();
  pvc_cipher_if cipher_ch ();
  pvc_cfg_if    cfg_ch ();

  printable_vigenere_cipher_unit dut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_ch),
    .cipher_out (cipher_ch),
    .cfg        (cfg_ch)
  );

  // cipher model state
  logic [63:0] key_low_q;
  logic [63:0] key_high_q;
  logic [4:0]  key_len_q;
  logic        decrypt_q;
  logic [3:0]  key_pos_q;

  cipher_result_t pending_cipher[$];
  int error_count = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  bit hold_request = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_cipher.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic expect_cipher(input logic [7:0] b, input logic last);
    int unsigned len;
    int unsigned pos;
    int unsigned kb;
    int unsigned shift;
    int unsigned sym;
    logic [63:0] word;
    cipher_result_t want;
    len = 32'(key_len_q);
    if (len == 0) len = 1;
    if (len > pvc_pkg::KEY_CHARS) len = pvc_pkg::KEY_CHARS;
    pos = 32'(key_pos_q);
    if (pos >= len) pos = 0;
    want.cipher_byte = b;
    want.last_out = last;
    if (b >= pvc_pkg::FIRST_PRINT && b <= pvc_pkg::LAST_PRINT) begin
      word = (pos >= 8) ? key_high_q : key_low_q;
      kb = 32'((word >> ((pos % 8) * 8)) & 64'hFF);
      shift = (kb + 32'd63) % 32'(pvc_pkg::ALPHABET);
      sym = 32'(b) - 32'(pvc_pkg::FIRST_PRINT);
      if (decrypt_q) begin
        sym = (sym + 32'(pvc_pkg::ALPHABET) - shift) % 32'(pvc_pkg::ALPHABET);
      end else begin
        sym = (sym + shift) % 32'(pvc_pkg::ALPHABET);
      end
      want.cipher_byte = 8'(sym + 32'(pvc_pkg::FIRST_PRINT));
    end
    if (last) begin
      key_pos_q = '0;
    end else begin
      key_pos_q = (pos + 1 >= len) ? 4'd0 : 4'(pos + 1);
    end
    pending_cipher.push_back(want);
  endtask

  // one process sees every transfer so model updates and checks stay in order
  always @(posedge clk) begin : monitor
    cipher_result_t got;
    cipher_result_t want;
    if (rst) begin
      key_low_q  = '0;
      key_high_q = '0;
      key_len_q  = 5'd1;
      decrypt_q  = 1'b0;
      key_pos_q  = '0;
      pending_cipher.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          pvc_pkg::REG_KEY_LOW:  key_low_q  = cfg_ch.data;
          pvc_pkg::REG_KEY_HIGH: key_high_q = cfg_ch.data;
          pvc_pkg::REG_KEY_LEN:  key_len_q  = cfg_ch.data[4:0];
          pvc_pkg::REG_DECRYPT:  decrypt_q  = cfg_ch.data[0];
          default: ;
        endcase
      end
      if (text_ch.valid && text_ch.ready) begin
        expect_cipher(text_ch.text_byte, text_ch.last_of_message);
      end
      if (cipher_ch.valid && cipher_ch.ready) begin
        got.cipher_byte = cipher_ch.cipher_byte;
        got.last_out = cipher_ch.last_out;
        if (pending_cipher.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: unexpected result: expected none, actual byte %h last %b",
                     $time, got.cipher_byte, got.last_out);
          end
        end else begin
          want = pending_cipher.pop_front();
          if (got.cipher_byte !== want.cipher_byte) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: cipher_byte mismatch: expected %h, actual %h",
                       $time, want.cipher_byte, got.cipher_byte);
            end
          end
          if (got.last_out !== want.last_out) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: last_out mismatch: expected %b, actual %b",
                       $time, want.last_out, got.last_out);
            end
          end
        end
      end
    end
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    cipher_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        cipher_ch.ready = 1'b0;
      end else begin
        cipher_ch.ready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer with valid still high
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      text_ch.valid = 1'b0;
      @(negedge clk);
    end
    text_ch.valid = 1'b1;
    text_ch.text_byte = b;
    text_ch.last_of_message = last;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    text_ch.valid = 1'b0;
    while (pending_cipher.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pvc_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [7:0] random_text_byte();
    if ($urandom_range(3) != 0) begin
      return 8'($urandom_range(pvc_pkg::LAST_PRINT, pvc_pkg::FIRST_PRINT));
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [63:0] random_key_word();
    logic [63:0] w;
    for (int i = 0; i < pvc_pkg::CHARS_PER_WORD; i++) begin
      if ($urandom_range(7) != 0) begin
        w[i*8 +: 8] = 8'($urandom_range(pvc_pkg::LAST_PRINT, pvc_pkg::FIRST_PRINT));
      end else begin
        w[i*8 +: 8] = 8'($urandom_range(255));
      end
    end
    return w;
  endfunction

  // key all zero after reset: every key character is non-printable
  task automatic test_reset_state();
    send_byte("A", 1'b0);
    send_byte(" ", 1'b0);
    send_byte("~", 1'b1);
    wait_idle();
  endtask

  task automatic test_byte_extremes();
    logic [7:0] edge_bytes[8];
    edge_bytes = '{8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'hFF, 8'h41};
    write_reg(pvc_pkg::REG_KEY_LOW, 64'h7E20_4B65_7921_5A7E);
    write_reg(pvc_pkg::REG_KEY_HIGH, 64'h207E_3030_6D2A_7E20);
    write_reg(pvc_pkg::REG_KEY_LEN, 64'd16);
    for (int i = 0; i < 8; i++) send_byte(edge_bytes[i], i == 7);
    wait_idle();
    write_reg(pvc_pkg::REG_DECRYPT, 64'h1);
    for (int i = 2; i < 6; i++) send_byte(edge_bytes[i], i == 5);
    wait_idle();
  endtask

  task automatic test_length_corners();
    write_reg(pvc_pkg::REG_KEY_LEN, 64'd0);
    send_byte("z", 1'b0);
    send_byte("z", 1'b1);
    wait_idle();
    write_reg(pvc_pkg::REG_KEY_LEN, 64'd31);
    write_reg(pvc_pkg::REG_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFE);
    send_byte("~", 1'b0);
    wait_idle();
    // upper data bits must be ignored
    write_reg(pvc_pkg::REG_KEY_LEN, 64'hFFFF_FFFF_FFFF_FFE3);
    send_byte("q", 1'b0);
    wait_idle();
    // position left beyond a shortened key
    write_reg(pvc_pkg::REG_KEY_LEN, 64'd16);
    for (int i = 0; i < 9; i++) begin
      send_byte(8'($urandom_range(pvc_pkg::LAST_PRINT, pvc_pkg::FIRST_PRINT)), 1'b0);
    end
    wait_idle();
    write_reg(pvc_pkg::REG_KEY_LEN, 64'd4);
    send_byte("M", 1'b0);
    send_byte("N", 1'b1);
    wait_idle();
  endtask

  task automatic test_odd_registers();
    write_reg(REG_UNUSED, '1);
    write_reg(pvc_pkg::REG_KEY_HIGH, 64'hFF00_8019_7F7F_1F00);
    write_reg(pvc_pkg::REG_KEY_LEN, 64'd16);
    for (int i = 0; i < 16; i++) send_byte("g", i == 15);
    wait_idle();
  endtask

  task automatic setup_random_key(input int setting);
    logic [63:0] len_word;
    logic [4:0]  len;
    case (setting)
      0: len = 5'd1;
      1: len = 5'd16;
      default: begin
        if ($urandom_range(4) == 0) len = 5'($urandom_range(31));
        else len = 5'($urandom_range(16, 1));
      end
    endcase
    len_word = {$urandom, $urandom};
    len_word[4:0] = len;
    write_reg(pvc_pkg::REG_KEY_LOW, random_key_word());
    write_reg(pvc_pkg::REG_KEY_HIGH, random_key_word());
    write_reg(pvc_pkg::REG_KEY_LEN, len_word);
    write_reg(pvc_pkg::REG_DECRYPT, {$urandom, $urandom});
    if ($urandom_range(2) == 0) begin
      write_reg(8'($urandom_range(255, int'(pvc_pkg::REG_DECRYPT) + 1)), {$urandom, $urandom});
    end
  endtask

  task automatic test_random_messages(input int src_pct, input int sink_pct, input int n_items);
    int sent;
    int msg_len;
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    for (int setting = 0; setting < 5; setting++) begin
      wait_idle();
      setup_random_key(setting);
      sent = 0;
      while (sent < n_items / 5) begin
        msg_len = $urandom_range(40, 1);
        for (int i = 0; i < msg_len; i++) begin
          send_byte(random_text_byte(), (i == msg_len - 1) || ($urandom_range(19) == 0));
        end
        sent += msg_len;
      end
    end
    wait_idle();
  endtask

  // result side holds off while the sender keeps offering, so the input stalls
  task automatic test_output_stall();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++) send_byte(random_text_byte(), (i % 13) == 12);
    wait_idle();
  endtask

  initial begin
    text_ch.valid = 1'b0;
    text_ch.text_byte = '0;
    text_ch.last_of_message = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    src_idle_pct = 29;
    sink_idle_pct = 72;
    test_reset_state();
    test_byte_extremes();
    test_length_corners();
    test_odd_registers();
    test_random_messages(29, 72, 420);
    test_random_messages(72, 29, 420);
    test_random_messages(0, 0, 420);
    test_output_stall();
    wait_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* printable_vigenere_cipher_unit.f */
rtl/pvc_pkg.sv
rtl/pvc_ifs.sv
rtl/pvc_shift.sv
rtl/printable_vigenere_cipher_unit.sv
sim/testbench.sv
